// ===== rtl/core/hudc_pkg.sv =====
// hudc_pkg: constants, year table and helper functions for the hijri date converter
// no dependencies; used by hudc_rom and umalqura_hijri_date_converter
package hudc_pkg;

  localparam int TABLE_YEARS = 179;
  localparam int FIRST_YEAR  = 1318;
  localparam int ROM_ROWS    = 184;
  localparam int NROWS       = (TABLE_YEARS > ROM_ROWS) ? ROM_ROWS :
                               (TABLE_YEARS < 2) ? 2 : TABLE_YEARS;
  localparam int KW          = $clog2(NROWS);
  localparam int SHORT_MONTH = 29;
  localparam int LONG_YEAR   = 355;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP       = (1 << RECIP_SHIFT) / LONG_YEAR + 1;

  typedef struct packed {
    logic [11:0] mask;
    logic [11:0] gy;
    logic [3:0]  gm;
    logic [4:0]  gd;
  } year_row_t;

  typedef year_row_t rom_tab_t [ROM_ROWS];
  typedef logic [15:0] start_tab_t [NROWS];

  localparam rom_tab_t ROM = '{
    '{746,1900,4,30},'{1769,1901,4,19},'{3794,1902,4,9},'{3748,1903,3,30},'{3402,1904,3,18},
    '{2710,1905,3,7},'{1334,1906,2,24},'{2741,1907,2,13},'{3498,1908,2,3},'{2980,1909,1,23},
    '{2889,1910,1,12},'{2707,1911,1,1},'{1323,1911,12,21},'{2647,1912,12,9},'{1206,1913,11,29},
    '{2741,1914,11,18},'{1450,1915,11,8},'{3413,1916,10,27},'{3370,1917,10,17},'{2646,1918,10,6},
    '{1198,1919,9,25},'{2397,1920,9,13},'{748,1921,9,3},'{1749,1922,8,23},'{1706,1923,8,13},
    '{1365,1924,8,1},'{1195,1925,7,21},'{2395,1926,7,10},'{698,1927,6,30},'{1397,1928,6,18},
    '{2994,1929,6,8},'{1892,1930,5,29},'{1865,1931,5,18},'{1621,1932,5,6},'{683,1933,4,25},
    '{1371,1934,4,14},'{2778,1935,4,4},'{1748,1936,3,24},'{3785,1937,3,13},'{3474,1938,3,3},
    '{3365,1939,2,20},'{2637,1940,2,9},'{685,1941,1,28},'{1389,1942,1,17},'{2922,1943,1,7},
    '{2898,1943,12,28},'{2725,1944,12,16},'{2635,1945,12,5},'{1175,1946,11,24},
    '{2359,1947,11,13},
    '{694,1948,11,2},'{1397,1949,10,22},'{3434,1950,10,12},'{3410,1951,10,2},'{2710,1952,9,20},
    '{2349,1953,9,9},'{605,1954,8,29},'{1245,1955,8,18},'{2778,1956,8,7},'{1492,1957,7,28},
    '{3497,1958,7,17},'{3410,1959,7,7},'{2730,1960,6,25},'{1238,1961,6,14},'{2486,1962,6,3},
    '{884,1963,5,24},'{1897,1964,5,12},'{1874,1965,5,2},'{1701,1966,4,21},'{1355,1967,4,10},
    '{2731,1968,3,29},'{1370,1969,3,19},'{2773,1970,3,8},'{3538,1971,2,26},'{3492,1972,2,16},
    '{3401,1973,2,4},'{2709,1974,1,24},'{1325,1975,1,13},'{2653,1976,1,2},'{1370,1976,12,22},
    '{2773,1977,12,11},'{1706,1978,12,1},'{1685,1979,11,20},'{1323,1980,11,8},'{2647,1981,10,28},
    '{1198,1982,10,18},'{2422,1983,10,7},'{1388,1984,9,26},'{2901,1985,9,15},'{2730,1986,9,5},
    '{2645,1987,8,25},'{1197,1988,8,13},'{2397,1989,8,2},'{730,1990,7,23},'{1497,1991,7,12},
    '{3506,1992,7,1},'{2980,1993,6,21},'{2890,1994,6,10},'{2645,1995,5,30},'{693,1996,5,18},
    '{1397,1997,5,7},'{2922,1998,4,27},'{3026,1999,4,17},'{3012,2000,4,6},'{2953,2001,3,26},
    '{2709,2002,3,15},'{1325,2003,3,4},'{1453,2004,2,21},'{2922,2005,2,10},'{1748,2006,1,31},
    '{3529,2007,1,20},'{3474,2008,1,10},'{2726,2008,12,29},'{2390,2009,12,18},'{686,2010,12,7},
    '{1389,2011,11,26},'{874,2012,11,15},'{2901,2013,11,4},'{2730,2014,10,25},'{2381,2015,10,14},
    '{1181,2016,10,2},'{2397,2017,9,21},'{698,2018,9,11},'{1461,2019,8,31},'{1450,2020,8,20},
    '{3413,2021,8,9},'{2714,2022,7,30},'{2350,2023,7,19},'{622,2024,7,7},'{1373,2025,6,26},
    '{2778,2026,6,16},'{1748,2027,6,6},'{1701,2028,5,25},'{1355,2029,5,14},'{2711,2030,5,3},
    '{1358,2031,4,23},'{2734,2032,4,11},'{1452,2033,4,1},'{2985,2034,3,21},'{3474,2035,3,11},
    '{2853,2036,2,28},'{1611,2037,2,16},'{3243,2038,2,5},'{1370,2039,1,26},'{2901,2040,1,15},
    '{1746,2041,1,4},'{3749,2041,12,24},'{3658,2042,12,14},'{2709,2043,12,3},'{1325,2044,11,21},
    '{2733,2045,11,10},'{876,2046,10,31},'{1881,2047,10,20},'{1746,2048,10,9},'{1685,2049,9,28},
    '{1325,2050,9,17},'{2651,2051,9,6},'{1210,2052,8,26},'{2490,2053,8,15},'{948,2054,8,5},
    '{2921,2055,7,25},'{2898,2056,7,14},'{2726,2057,7,3},'{1206,2058,6,22},'{2413,2059,6,11},
    '{748,2060,5,31},'{1753,2061,5,20},'{3762,2062,5,10},'{3412,2063,4,30},'{3370,2064,4,18},
    '{2646,2065,4,7},'{1198,2066,3,27},'{2413,2067,3,16},'{3434,2068,3,5},'{2900,2069,2,23},
    '{2857,2070,2,12},'{2707,2071,2,1},'{1323,2072,1,21},'{2647,2073,1,9},'{1334,2073,12,30},
    '{2741,2074,12,19},'{1706,2075,12,9},'{3731,2076,11,27},'{0,2077,11,17}
  };

  function automatic int civil_days(input int yi, input int mi, input int di);
    int y;
    int m;
    y = yi;
    m = mi;
    if (m < 3) begin
      y = y - 1;
      m = m + 12;
    end
    return 365 * y + y / 4 - y / 100 + y / 400 + (153 * (m - 3) + 2) / 5 + di;
  endfunction

  function automatic start_tab_t build_starts();
    start_tab_t t;
    int base;
    base = civil_days(int'(ROM[0].gy), int'(ROM[0].gm), int'(ROM[0].gd));
    for (int i = 0; i < NROWS; i++) begin
      t[i] = 16'(civil_days(int'(ROM[i].gy), int'(ROM[i].gm), int'(ROM[i].gd)) - base);
    end
    return t;
  endfunction

  localparam start_tab_t START_TAB = build_starts();
  localparam logic [15:0] END_START = START_TAB[NROWS-1];

  function automatic logic [4:0] month_len(input logic [11:0] mask, input logic [3:0] m);
    logic [3:0] b;
    logic       bit_v;
    b = m - 4'd1;
    bit_v = (b < 4'd12) ? mask[b] : 1'b0;
    return 5'(SHORT_MONTH) + {4'd0, bit_v};
  endfunction

endpackage

// ===== rtl/core/hudc_rom.sv =====
// hudc_rom: registered year table read, start day of a row and of the next row plus mask
// depends on hudc_pkg
module hudc_rom (
  input  logic                 clk,
  input  logic [hudc_pkg::KW-1:0] addr,
  output logic [15:0]          start0_r,
  output logic [15:0]          start1_r,
  output logic [11:0]          mask_r
);
  import hudc_pkg::*;

  logic [KW:0] addr1;

  assign addr1 = {1'b0, addr} + {{KW{1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    start0_r <= (int'(addr) < NROWS) ? START_TAB[addr] : 16'd0;
    start1_r <= (int'(addr1) < NROWS) ? START_TAB[addr1[KW-1:0]] : 16'd0;
    mask_r   <= (int'(addr) < NROWS) ? ROM[addr].mask : 12'd0;
  end

endmodule

// ===== rtl/core/umalqura_hijri_date_converter.sv =====
// umalqura_hijri_date_converter: top level, sequencer and add/compare datapath
// depends on hudc_pkg and hudc_rom
//
// Converts a day count (days since 1900-04-30) to an Umm al-Qura Hijri date
// (in_mode 0) or a Hijri date to a day count (in_mode 1), years 1318 to 1495.
// Pulse start while busy is low; busy stays high until the result goes out.
// Each result appears for one cycle with out_valid high and cannot be stalled,
// so the receiver must take it in that cycle. Out-of-range input gives
// out_range_error with all other fields zero. The result follows in the first
// cycle with busy low. A range error is found at the first check or, for a day
// beyond the month's length, at the length lookup. A valid day count takes a
// check, one step back that never moves, one or two steps forward in the year
// table and a walk of one month at a time, up to twelve. A valid Hijri date
// takes a check, a length lookup and a sum of one month at a time, up to
// twelve. Every table lookup goes through the single table read port.
module umalqura_hijri_date_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [15:0] in_day_offset,
  input  logic [10:0] in_hijri_year,
  input  logic [3:0]  in_hijri_month,
  input  logic [4:0]  in_hijri_day,
  output logic        out_valid,
  output logic [10:0] out_year_out,
  output logic [3:0]  out_month_out,
  output logic [4:0]  out_day_out,
  output logic [8:0]  out_day_of_year,
  output logic [4:0]  out_month_length,
  output logic [15:0] out_offset_out,
  output logic        out_range_error
);
  import hudc_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_CHK0 = 8'b0000_0010,
    S_DN   = 8'b0000_0100,
    S_UP   = 8'b0000_1000,
    S_WALK = 8'b0001_0000,
    S_CHK1 = 8'b0010_0000,
    S_LEN1 = 8'b0100_0000,
    S_SUM  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [15:0] off_r, off_nxt;
  logic [10:0] year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic [8:0]  doy_r, doy_nxt;
  logic [3:0]  mcnt_r, mcnt_nxt;
  logic [4:0]  len_r, len_nxt;

  logic        ov_r, ov_nxt;
  logic [10:0] oy_r, oy_nxt;
  logic [3:0]  om_r, om_nxt;
  logic [4:0]  od_r, od_nxt;
  logic [8:0]  odoy_r, odoy_nxt;
  logic [4:0]  olen_r, olen_nxt;
  logic [15:0] ooff_r, ooff_nxt;
  logic        oerr_r, oerr_nxt;

  logic [15:0] start0_r, start1_r;
  logic [11:0] mask_r;
  logic [32:0] est_prod;
  logic [8:0]  est;
  logic [4:0]  cur_len;
  logic [15:0] diff;

  hudc_rom u_rom (
    .clk      (clk),
    .addr     (k_nxt),
    .start0_r (start0_r),
    .start1_r (start1_r),
    .mask_r   (mask_r)
  );

  assign est_prod = {17'd0, off_r} * 33'(RECIP);
  assign est      = est_prod[RECIP_SHIFT+8:RECIP_SHIFT];
  assign cur_len  = month_len(mask_r, mcnt_r);
  assign diff     = off_r - start0_r;

  always_comb begin
    state_nxt = state_r;
    off_nxt   = off_r;
    year_nxt  = year_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    k_nxt     = k_r;
    rem_nxt   = rem_r;
    doy_nxt   = doy_r;
    mcnt_nxt  = mcnt_r;
    len_nxt   = len_r;
    ov_nxt    = 1'b0;
    oy_nxt    = oy_r;
    om_nxt    = om_r;
    od_nxt    = od_r;
    odoy_nxt  = odoy_r;
    olen_nxt  = olen_r;
    ooff_nxt  = ooff_r;
    oerr_nxt  = oerr_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          off_nxt   = in_day_offset;
          year_nxt  = in_hijri_year;
          month_nxt = in_hijri_month;
          day_nxt   = in_hijri_day;
          state_nxt = in_mode ? S_CHK1 : S_CHK0;
        end
      end
      S_CHK0: begin
        if (off_r >= END_START) begin
          ov_nxt = 1'b1; oy_nxt = '0; om_nxt = '0; od_nxt = '0;
          odoy_nxt = '0; olen_nxt = '0; ooff_nxt = '0; oerr_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          k_nxt = (int'(est) > NROWS - 2) ? KW'(NROWS - 2) : KW'(est);
          state_nxt = S_DN;
        end
      end
      S_DN: begin
        if (k_r != '0 && start0_r > off_r) begin
          k_nxt = k_r - KW'(1);
        end else begin
          state_nxt = S_UP;
        end
      end
      S_UP: begin
        if ((int'(k_r) + 1 < NROWS - 1) && start1_r <= off_r) begin
          k_nxt = k_r + KW'(1);
        end else begin
          rem_nxt   = diff[8:0];
          doy_nxt   = diff[8:0] + 9'd1;
          mcnt_nxt  = 4'd1;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if ({4'd0, cur_len} <= rem_r && mcnt_r < 4'd12) begin
          rem_nxt  = rem_r - {4'd0, cur_len};
          mcnt_nxt = mcnt_r + 4'd1;
        end else begin
          ov_nxt    = 1'b1;
          oy_nxt    = 11'(FIRST_YEAR) + 11'(k_r);
          om_nxt    = mcnt_r;
          od_nxt    = rem_r[4:0] + 5'd1;
          odoy_nxt  = doy_r;
          olen_nxt  = cur_len;
          ooff_nxt  = off_r;
          oerr_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      S_CHK1: begin
        if ({1'b0, year_r} < 12'(FIRST_YEAR) ||
            {1'b0, year_r} >= 12'(FIRST_YEAR + NROWS - 1) ||
            month_r < 4'd1 || month_r > 4'd12 || day_r < 5'd1) begin
          ov_nxt = 1'b1; oy_nxt = '0; om_nxt = '0; od_nxt = '0;
          odoy_nxt = '0; olen_nxt = '0; ooff_nxt = '0; oerr_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          k_nxt     = KW'(year_r - 11'(FIRST_YEAR));
          mcnt_nxt  = month_r;
          state_nxt = S_LEN1;
        end
      end
      S_LEN1: begin
        if (day_r > cur_len) begin
          ov_nxt = 1'b1; oy_nxt = '0; om_nxt = '0; od_nxt = '0;
          odoy_nxt = '0; olen_nxt = '0; ooff_nxt = '0; oerr_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          len_nxt   = cur_len;
          doy_nxt   = {4'd0, day_r};
          mcnt_nxt  = 4'd1;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (mcnt_r < month_r) begin
          doy_nxt  = doy_r + {4'd0, cur_len};
          mcnt_nxt = mcnt_r + 4'd1;
        end else begin
          ov_nxt    = 1'b1;
          oy_nxt    = year_r;
          om_nxt    = month_r;
          od_nxt    = day_r;
          odoy_nxt  = doy_r;
          olen_nxt  = len_r;
          ooff_nxt  = start0_r + {7'd0, doy_r} - 16'd1;
          oerr_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r   <= off_nxt;
    year_r  <= year_nxt;
    month_r <= month_nxt;
    day_r   <= day_nxt;
    rem_r   <= rem_nxt;
    doy_r   <= doy_nxt;
    mcnt_r  <= mcnt_nxt;
    len_r   <= len_nxt;
    oy_r    <= oy_nxt;
    om_r    <= om_nxt;
    od_r    <= od_nxt;
    odoy_r  <= odoy_nxt;
    olen_r  <= olen_nxt;
    ooff_r  <= ooff_nxt;
    oerr_r  <= oerr_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = ov_r;
  assign out_year_out     = oy_r;
  assign out_month_out    = om_r;
  assign out_day_out      = od_r;
  assign out_day_of_year  = odoy_r;
  assign out_month_length = olen_r;
  assign out_offset_out   = ooff_r;
  assign out_range_error  = oerr_r;

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("transfer accepted but block not busy");
  a_valid_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) && !busy) else $error("result without a conversion");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |-> out_year_out == 11'd0 && out_offset_out == 16'd0)
    else $error("range error with nonzero fields");
  a_len_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_range_error |-> out_month_length == 5'd29 || out_month_length == 5'd30)
    else $error("bad month length");
`endif

endmodule

// ===== tb/umalqura_hijri_date_converter_tb.sv =====
// umalqura_hijri_date_converter_tb: self-checking testbench for the hijri date converter
// depends on hudc_pkg and umalqura_hijri_date_converter; predicts every conversion in both
// directions from the ROM masks and its own year starts; checks each output field by field
`timescale 1ns / 100ps

module umalqura_hijri_date_converter_tb;
  import hudc_pkg::*;

  localparam int LAST_YEAR   = FIRST_YEAR + NROWS - 2;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [10:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [8:0]  doy;
    logic [4:0]  mlen;
    logic [15:0] offset;
    logic        range_err;
  } hijri_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_mode;
  logic [15:0] in_day_offset;
  logic [10:0] in_hijri_year;
  logic [3:0]  in_hijri_month;
  logic [4:0]  in_hijri_day;
  logic        out_valid;
  logic [10:0] out_year_out;
  logic [3:0]  out_month_out;
  logic [4:0]  out_day_out;
  logic [8:0]  out_day_of_year;
  logic [4:0]  out_month_length;
  logic [15:0] out_offset_out;
  logic        out_range_error;

  hijri_result_t pending_dates[$];
  int            year_start[NROWS];
  int            fail_count;
  int            cycle_count;

  umalqura_hijri_date_converter i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // own day-count table of year starts
  function automatic int days_from_civil(int y, int m, int d);
    if (m < 3) begin
      y = y - 1;
      m = m + 12;
    end
    return 365 * y + y / 4 - y / 100 + y / 400 + (153 * (m - 3) + 2) / 5 + d;
  endfunction

  function automatic int days_in_month(logic [11:0] mask, int m);
    return 29 + int'(mask[m - 1]);
  endfunction

  function automatic hijri_result_t convert_date(logic mode, logic [15:0] offs,
                                                 logic [10:0] yr, logic [3:0] mo,
                                                 logic [4:0] dy);
    hijri_result_t r;
    int k;
    int rem;
    int m;
    int len;
    int doy;
    logic [11:0] mask;
    r = '0;
    if (mode == 1'b0) begin
      if (int'(offs) >= year_start[NROWS - 1]) begin
        r.range_err = 1'b1;
        return r;
      end
      k = 0;
      while (k + 1 < NROWS - 1 && year_start[k + 1] <= int'(offs)) k++;
      rem = int'(offs) - year_start[k];
      doy = rem + 1;
      mask = ROM[k].mask;
      m = 1;
      len = days_in_month(mask, 1);
      while (rem >= len && m < 12) begin
        rem -= len;
        m++;
        len = days_in_month(mask, m);
      end
      r.year = 11'(FIRST_YEAR + k);
      r.month = 4'(m);
      r.day = 5'(rem + 1);
      r.doy = 9'(doy);
      r.mlen = 5'(len);
      r.offset = offs;
    end else begin
      if (int'(yr) < FIRST_YEAR || int'(yr) > LAST_YEAR || mo < 1 || mo > 12 || dy < 1) begin
        r.range_err = 1'b1;
        return r;
      end
      k = int'(yr) - FIRST_YEAR;
      mask = ROM[k].mask;
      len = days_in_month(mask, int'(mo));
      if (int'(dy) > len) begin
        r.range_err = 1'b1;
        return r;
      end
      doy = int'(dy);
      for (int i = 1; i < int'(mo); i++) doy += days_in_month(mask, i);
      r.year = yr;
      r.month = mo;
      r.day = dy;
      r.doy = 9'(doy);
      r.mlen = 5'(len);
      r.offset = 16'(year_start[k] + doy - 1);
    end
    return r;
  endfunction

  // at least one edge so start is never driven twice in one time step
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    repeat (n) @(posedge clk);
  endtask

  task automatic send_conversion(logic mode, logic [15:0] offs, logic [10:0] yr,
                                 logic [3:0] mo, logic [4:0] dy, bit gaps = 1'b1);
    if (gaps) idle_gap();
    else @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b1;
    in_mode <= mode;
    in_day_offset <= offs;
    in_hijri_year <= yr;
    in_hijri_month <= mo;
    in_hijri_day <= dy;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_dates.push_back(convert_date(mode, offs, yr, mo, dy));
    start <= 1'b0;
  endtask

  task automatic send_day_count(logic [15:0] offs);
    send_conversion(1'b0, offs, 11'($urandom), 4'($urandom), 5'($urandom));
  endtask

  task automatic send_hijri(logic [10:0] yr, logic [3:0] mo, logic [4:0] dy);
    send_conversion(1'b1, 16'($urandom), yr, mo, dy);
  endtask

  task automatic wait_drained();
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_day_count(16'd0);
    send_day_count(16'(year_start[1] - 1));
    send_day_count(16'(year_start[1]));
    send_day_count(16'(year_start[NROWS - 1] - 1));
    send_day_count(16'(year_start[NROWS - 1]));
    send_day_count(16'hffff);
    send_day_count(16'd64849);
    send_hijri(11'(FIRST_YEAR), 4'd1, 5'd1);
    send_hijri(11'(LAST_YEAR), 4'd12, 5'(days_in_month(ROM[NROWS - 2].mask, 12)));
    send_hijri(11'(FIRST_YEAR - 1), 4'd1, 5'd1);
    send_hijri(11'(LAST_YEAR + 1), 4'd1, 5'd1);
    send_hijri(11'h7ff, 4'd6, 5'd10);
    send_hijri(11'd0, 4'd6, 5'd10);
    send_hijri(11'd1400, 4'd0, 5'd1);
    send_hijri(11'd1400, 4'd13, 5'd1);
    send_hijri(11'd1400, 4'd15, 5'd31);
    send_hijri(11'd1400, 4'd5, 5'd0);
    send_hijri(11'd1400, 4'd5, 5'd30);
    send_hijri(11'd1400, 4'd6, 5'd30);
    send_hijri(11'd1400, 4'd7, 5'd31);
    send_hijri(11'd1450, 4'd12, 5'd29);
    wait_drained();
  endtask

  task automatic test_random();
    int sel;
    int yr;
    for (int i = 0; i < 900; i++) begin
      sel = $urandom_range(0, 9);
      yr = $urandom_range(FIRST_YEAR, LAST_YEAR);
      if (i == 450) wait_drained();
      if (sel < 4) begin
        send_day_count(16'($urandom_range(0, year_start[NROWS - 1] - 1)));
      end else if (sel < 8) begin
        send_hijri(11'(yr), 4'($urandom_range(1, 12)), 5'($urandom_range(1, 30)));
      end else if (sel == 8) begin
        send_day_count(16'($urandom));
      end else begin
        send_hijri(11'($urandom), 4'($urandom), 5'($urandom));
      end
    end
  endtask

  always @(posedge clk) begin
    hijri_result_t e;
    if (rst_n && out_valid) begin
      if (pending_dates.size() == 0) begin
        $error("unexpected output transfer");
        fail_count++;
      end else begin
        e = pending_dates.pop_front();
        if (out_year_out !== e.year) begin
          $error("year_out exp %0d got %0d", e.year, out_year_out);
          fail_count++;
        end
        if (out_month_out !== e.month) begin
          $error("month_out exp %0d got %0d", e.month, out_month_out);
          fail_count++;
        end
        if (out_day_out !== e.day) begin
          $error("day_out exp %0d got %0d", e.day, out_day_out);
          fail_count++;
        end
        if (out_day_of_year !== e.doy) begin
          $error("day_of_year exp %0d got %0d", e.doy, out_day_of_year);
          fail_count++;
        end
        if (out_month_length !== e.mlen) begin
          $error("month_length exp %0d got %0d", e.mlen, out_month_length);
          fail_count++;
        end
        if (out_offset_out !== e.offset) begin
          $error("offset_out exp %0d got %0d", e.offset, out_offset_out);
          fail_count++;
        end
        if (out_range_error !== e.range_err) begin
          $error("range_error exp %0d got %0d", e.range_err, out_range_error);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    fail_count = 0;
    cycle_count = 0;
    for (int i = 0; i < NROWS; i++) begin
      year_start[i] = days_from_civil(ROM[i].gy, ROM[i].gm, ROM[i].gd) -
                      days_from_civil(ROM[0].gy, ROM[0].gm, ROM[0].gd);
    end
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = 1'b0;
    in_day_offset = '0;
    in_hijri_year = '0;
    in_hijri_month = '0;
    in_hijri_day = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_dates.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
